// ===== src/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Types, constants and helper functions shared by the protocol classifier.
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int unsigned METHOD_COUNT = 9;

	localparam logic [5:0] TAKE_LIMIT = 6'd60;
	localparam logic [5:0] HEX_RUN    = 6'd56;
	localparam logic [5:0] VLESS_MIN  = 6'd22;

	localparam logic [7:0] BYTE_SOCKS5 = 8'h05;
	localparam logic [7:0] BYTE_TLS    = 8'h16;
	localparam logic [7:0] BYTE_TLS_V  = 8'h03;
	localparam logic [7:0] BYTE_DEL    = 8'h7F;
	localparam logic [7:0] BYTE_ATYP4  = 8'h04;
	localparam logic [7:0] BYTE_CR     = 8'h0D;
	localparam logic [7:0] BYTE_LF     = 8'h0A;

	// Method prefixes, left aligned, padded with spaces past their length.
	localparam logic [63:0] METHOD_TEXT [METHOD_COUNT] = '{
		"GET     ", "POST    ", "HEAD    ", "PUT     ", "DELETE  ",
		"CONNECT ", "OPTIONS ", "TRACE   ", "PATCH   "
	};
	localparam logic [3:0] METHOD_LEN [METHOD_COUNT] = '{
		4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6, 4'd6
	};

	typedef enum logic [2:0] {
		CLS_UNKNOWN = 3'd0,
		CLS_SOCKS5  = 3'd1,
		CLS_TLS     = 3'd2,
		CLS_HTTP    = 3'd3,
		CLS_SHADOW  = 3'd4,
		CLS_VLESS   = 3'd5,
		CLS_TROJAN  = 3'd6
	} class_t;

	typedef enum logic {
		MODE_OUTER = 1'b0,
		MODE_INNER = 1'b1
	} mode_t;

	typedef struct packed {
		logic [5:0] position;
		logic [8:0] method_alive;
		logic       http_seen;
		logic [7:0] first_value;
		logic       tls_second_ok;
		logic       vless_ok;
		logic       hex_run_ok;
		logic       trojan_tail_ok;
	} cpc_state_t;

	localparam cpc_state_t STATE_RESET = '{
		position:       6'd0,
		method_alive:   9'h1FF,
		http_seen:      1'b0,
		first_value:    8'h00,
		tls_second_ok:  1'b0,
		vless_ok:       1'b1,
		hex_run_ok:     1'b1,
		trojan_tail_ok: 1'b1
	};

	function automatic logic [7:0] method_char(input int m, input logic [2:0] idx);
		logic [63:0] text;
		text = METHOD_TEXT[m];
		return text[(7 - idx) * 8 +: 8];
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
			(c >= "A" && c <= "F");
	endfunction

	function automatic class_t classify(input mode_t mode, input cpc_state_t st);
		class_t cls;
		if (mode == MODE_OUTER) begin
			if (st.position == 6'd0)
				cls = CLS_UNKNOWN;
			else if (st.first_value == BYTE_SOCKS5)
				cls = CLS_SOCKS5;
			else if (st.position >= 6'd2 && st.first_value == BYTE_TLS && st.tls_second_ok)
				cls = CLS_TLS;
			else if (st.http_seen)
				cls = CLS_HTTP;
			else
				cls = CLS_SHADOW;
		end else begin
			if (st.http_seen)
				cls = CLS_HTTP;
			else if (st.position >= VLESS_MIN && st.vless_ok)
				cls = CLS_VLESS;
			else if (st.position >= TAKE_LIMIT)
				cls = (st.hex_run_ok && st.trojan_tail_ok) ? CLS_TROJAN : CLS_SHADOW;
			else
				cls = CLS_UNKNOWN;
		end
		return cls;
	endfunction

endpackage

// ===== src/cpc_if.sv =====
// ----------------------------------------------------------------------------
// cpc_if
// Valid/ready channels of the protocol classifier: byte requests, class
// results and mode register writes.
// ----------------------------------------------------------------------------
interface cpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output data_byte, output has_byte, output last,
		input ready);
	modport sink (input valid, input data_byte, input has_byte, input last,
		output ready);
endinterface

interface cpc_class_if;
	logic       valid;
	logic       ready;
	logic [2:0] protocol_class;

	modport source (output valid, output protocol_class, input ready);
	modport sink (input valid, input protocol_class, output ready);
endinterface

interface cpc_cfg_if;
	logic valid;
	logic ready;
	logic mode;

	modport source (output valid, output mode, input ready);
	modport sink (input valid, input mode, output ready);
endinterface

// ===== src/cpc_tracker.sv =====
// ----------------------------------------------------------------------------
// cpc_tracker
// Per-stream match flags: folds one byte into the flags and returns them to
// reset at the end of each buffer.
// ----------------------------------------------------------------------------
module cpc_tracker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   has_byte,
	input  logic                   last,
	output cpc_pkg::cpc_state_t    cur,
	output cpc_pkg::cpc_state_t    upd
);
	import cpc_pkg::*;

	cpc_state_t state_q;
	cpc_state_t take;
	logic [5:0] p;
	logic [7:0] b;

	assign p   = state_q.position;
	assign b   = data_byte;
	assign cur = state_q;

	// Fold the byte into every flag at once; each check looks at its own position.
	always_comb begin
		take = state_q;
		if (p < TAKE_LIMIT) begin
			if (p == 6'd0)
				take.first_value = b;
			if (p == 6'd1)
				take.tls_second_ok = (b == BYTE_TLS_V);
			for (int m = 0; m < METHOD_COUNT; m++) begin
				if (state_q.method_alive[m] && p < {2'b00, METHOD_LEN[m]}) begin
					if (b != method_char(m, p[2:0]))
						take.method_alive[m] = 1'b0;
					else if (p + 6'd1 == {2'b00, METHOD_LEN[m]})
						take.http_seen = 1'b1;
				end
			end
			if ((p == 6'd0 || p == 6'd17) && b != 8'h00)
				take.vless_ok = 1'b0;
			if (p == 6'd18 && !(b == 8'h01 || b == 8'h02 || b == BYTE_DEL))
				take.vless_ok = 1'b0;
			if (p == 6'd21 && !(b == 8'h01 || b == 8'h02 || b == 8'h03))
				take.vless_ok = 1'b0;
			if (p < HEX_RUN && !is_hex(b))
				take.hex_run_ok = 1'b0;
			if ((p == 6'd56 && b != BYTE_CR) || (p == 6'd57 && b != BYTE_LF))
				take.trojan_tail_ok = 1'b0;
			if (p == 6'd58 && !(b == 8'h01 || b == 8'h03 || b == BYTE_DEL))
				take.trojan_tail_ok = 1'b0;
			if (p == 6'd59 && !(b == 8'h01 || b == 8'h03 || b == BYTE_ATYP4))
				take.trojan_tail_ok = 1'b0;
			take.position = p + 6'd1;
		end
	end

	assign upd = has_byte ? take : state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (step) begin
			state_q <= last ? STATE_RESET : upd;
		end
	end

endmodule

// ===== src/connection_protocol_classifier_core.sv =====
// ----------------------------------------------------------------------------
// connection_protocol_classifier_core
// Streaming classifier for the first peeked bytes of a connection.
// ----------------------------------------------------------------------------
// Accepts one byte request per clock cycle unless a last request waits in
// the input register for a full result slot, and returns one protocol class
// per last request, via the input then the result register. A waiting result
// only stalls a following last request; plain byte requests keep flowing
// underneath it. The match flags live in one register set updated once per
// byte, so no buffer of the data is kept. The mode register is written
// through the cfg channel (always ready) and must only change while no
// buffer is in flight.
module connection_protocol_classifier_core (
	input  logic         clk,
	input  logic         arst_n,
	cpc_byte_if.sink     byte_ch,
	cpc_class_if.source  class_ch,
	cpc_cfg_if.sink      cfg
);
	import cpc_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       has_s1;
	logic       last_s1;
	logic       advance_s1;

	// Result register
	logic       out_valid_q;
	class_t     class_q;

	mode_t      mode_q;
	cpc_state_t cur_state;
	cpc_state_t upd_state;

	// Mode register: written on every cfg handshake.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OUTER;
		end else if (cfg.valid) begin
			mode_q <= mode_t'(cfg.mode);
		end
	end

	// Advance the staged request unless it is a last one and the result slot is full and not being taken.
	assign advance_s1  = valid_s1 && (!last_s1 || !out_valid_q || class_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.valid && byte_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload holds while stalled; no reset needed.
	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			has_s1  <= byte_ch.has_byte;
			last_s1 <= byte_ch.last;
		end
	end

	cpc_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.data_byte (byte_s1),
		.has_byte  (has_s1),
		.last      (last_s1),
		.cur       (cur_state),
		.upd       (upd_state)
	);

	// Classify on the flags including this byte; drop the result slot when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (class_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			class_q <= classify(mode_q, upd_state);
		end
	end

	assign class_ch.valid          = out_valid_q;
	assign class_ch.protocol_class = class_q;

	// A result appears only after a last request left the input stage.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance_s1 && last_s1))
		else $error("result raised without a last request");

	// The position counter saturates at the take limit.
	a_position_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cur_state.position <= TAKE_LIMIT)
		else $error("position counter beyond limit");

	// Outer mode never reports an inner-only class.
	a_outer_classes: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && last_s1 && mode_q == MODE_OUTER
		|=> class_q != CLS_VLESS && class_q != CLS_TROJAN)
		else $error("inner class reported in outer mode");

endmodule
